// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: consequent did not hold in the same cycle");

// Consequent must hold in the cycle after the antecedent completes.
`define BTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: consequent did not hold in the next cycle");

`endif

// ----- hw/rtl/btd_pkg.sv -----
package btd_pkg;

    localparam int COORD_W   = 12;
    localparam int PIXEL_W   = 16;
    localparam int CHAN_W    = 8;
    localparam int THR_W     = 4;
    localparam int ALPHA_W   = 8;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 1'b1;

    // Output modes; the unused code behaves as a plain pack.
    localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COLOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MONO  = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_ZERO  = 8'h00;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 8'hFF;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'hFF;
    localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_COLOR;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [MODE_W-1:0]  mode;
    } cfg_t;

    // Blended channels and the thresholds still to be added, per pixel.
    typedef struct packed {
        logic [2:0][CHAN_W-1:0] chan;
        logic [2:0][THR_W-1:0]  thr;
        logic                   last;
    } blend_t;

    // Ordered dither thresholds, one packed row per table row; column 0 sits
    // in the lowest nibble.
    localparam logic [7:0][THR_W-1:0] THR_RED [8] = '{
        32'h62805371, 32'h26083517, 32'h71628053, 32'h17260835,
        32'h53716280, 32'h35172608, 32'h80537162, 32'h08351726
    };

    localparam logic [7:0][THR_W-1:0] THR_GREEN [8] = '{
        32'h22132231, 32'h04224022, 32'h22312213, 32'h40220422,
        32'h22132231, 32'h04224022, 32'h22312213, 32'h40220422
    };

    localparam logic [7:0][THR_W-1:0] THR_BLUE [8] = '{
        32'h17260835, 32'h71628053, 32'h35172608, 32'h53716280,
        32'h08351726, 32'h80537162, 32'h26083517, 32'h62805371
    };

endpackage

// ----- hw/rtl/btd_stream_if.sv -----
interface btd_pix_if;
    logic                         valid;
    logic                         ready;
    logic [btd_pkg::COORD_W-1:0]  column;
    logic [btd_pkg::COORD_W-1:0]  row;
    logic [btd_pkg::PIXEL_W-1:0]  bottom_pixel;
    logic [btd_pkg::PIXEL_W-1:0]  top_pixel;
    logic                         last_pixel;

    modport source (
        output valid, column, row, bottom_pixel, top_pixel, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, column, row, bottom_pixel, top_pixel, last_pixel,
        output ready
    );
endinterface

interface btd_res_if;
    logic                         valid;
    logic                         ready;
    logic [btd_pkg::PIXEL_W-1:0]  pixel_out;
    logic                         end_of_line;

    modport source (
        output valid, pixel_out, end_of_line,
        input  ready
    );

    modport sink (
        input  valid, pixel_out, end_of_line,
        output ready
    );
endinterface

// ----- hw/rtl/btd_cfg.sv -----
module btd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [btd_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [btd_pkg::CFG_DATA_W-1:0]  wr_data,
    output btd_pkg::cfg_t                   cfg
);

    btd_pkg::cfg_t cfg_reg;
    btd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                btd_pkg::REG_BLEND_ALPHA: cfg_next.alpha = wr_data;
                btd_pkg::REG_OUTPUT_MODE: cfg_next.mode  = wr_data[btd_pkg::MODE_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha <= btd_pkg::ALPHA_RESET;
            cfg_reg.mode  <= btd_pkg::MODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/btd_blend.sv -----
module btd_blend (
    input  logic            clk,
    input  logic            rst_n,
    input  btd_pkg::cfg_t   cfg,
    btd_pix_if.sink         pixels,
    output logic            blend_valid,
    input  logic            blend_ready,
    output btd_pkg::blend_t blend_data
);

    localparam int WEIGHT_W = btd_pkg::ALPHA_W + 1;
    localparam int PROD_W   = 2 * btd_pkg::CHAN_W;

    // Stage 1: weighted products and thresholds.
    logic                                  s1_valid_reg;
    logic                                  s1_valid_next;
    logic                                  s1_ready;
    logic [2:0][PROD_W-1:0]                prod_bot_reg;
    logic [2:0][PROD_W-1:0]                prod_top_reg;
    logic [2:0][PROD_W-1:0]                prod_bot_next;
    logic [2:0][PROD_W-1:0]                prod_top_next;
    logic [2:0][btd_pkg::THR_W-1:0]        thr_reg;
    logic [2:0][btd_pkg::THR_W-1:0]        thr_next;
    logic                                  last_reg;

    // Stage 2: blended channels.
    logic                                  s2_valid_reg;
    logic                                  s2_valid_next;
    logic                                  s2_ready;
    btd_pkg::blend_t                       s2_data_reg;
    btd_pkg::blend_t                       s2_data_next;

    logic [2:0][btd_pkg::CHAN_W-1:0]       top_ch;
    logic [2:0][btd_pkg::CHAN_W-1:0]       bot_ch;
    logic [WEIGHT_W-1:0]                   top_weight;
    logic [WEIGHT_W-1:0]                   bot_weight;
    logic [2:0]                            tbl_row;
    logic [2:0]                            tbl_col;
    logic [btd_pkg::THR_W-1:0]             green_thr;

    assign s2_ready     = !s2_valid_reg || blend_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign pixels.ready = s1_ready;

    assign s1_valid_next = s1_ready ? pixels.valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    // The 5/6/5 fields land at the top of a byte.
    always_comb
    begin
        top_ch[0] = {pixels.top_pixel[15:11], 3'b000};
        top_ch[1] = {pixels.top_pixel[10:5], 2'b00};
        top_ch[2] = {pixels.top_pixel[4:0], 3'b000};
        bot_ch[0] = {pixels.bottom_pixel[15:11], 3'b000};
        bot_ch[1] = {pixels.bottom_pixel[10:5], 2'b00};
        bot_ch[2] = {pixels.bottom_pixel[4:0], 3'b000};
    end

    // Pass-through cases become weights of 256 and 0, so that the shift by
    // eight returns the chosen channel unchanged.
    always_comb
    begin
        if (pixels.top_pixel == pixels.bottom_pixel || cfg.alpha == btd_pkg::ALPHA_FULL)
        begin
            top_weight = WEIGHT_W'(256);
        end
        else if (cfg.alpha == btd_pkg::ALPHA_ZERO)
        begin
            top_weight = '0;
        end
        else
        begin
            top_weight = {1'b0, cfg.alpha};
        end
        bot_weight = WEIGHT_W'(256) - top_weight;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_top_next[i] = {{(PROD_W-btd_pkg::CHAN_W){1'b0}}, top_ch[i]}
                             * {{(PROD_W-WEIGHT_W){1'b0}}, top_weight};
            prod_bot_next[i] = {{(PROD_W-btd_pkg::CHAN_W){1'b0}}, bot_ch[i]}
                             * {{(PROD_W-WEIGHT_W){1'b0}}, bot_weight};
        end
    end

    assign tbl_row   = pixels.row[2:0];
    assign tbl_col   = pixels.column[2:0];
    assign green_thr = btd_pkg::THR_GREEN[tbl_row][tbl_col];

    always_comb
    begin
        case (cfg.mode)
            btd_pkg::MODE_COLOR:
            begin
                thr_next[0] = btd_pkg::THR_RED[tbl_row][tbl_col];
                thr_next[1] = green_thr;
                thr_next[2] = btd_pkg::THR_BLUE[tbl_row][tbl_col];
            end
            btd_pkg::MODE_MONO:
            begin
                thr_next[0] = {green_thr[btd_pkg::THR_W-2:0], 1'b0};
                thr_next[1] = green_thr;
                thr_next[2] = {green_thr[btd_pkg::THR_W-2:0], 1'b0};
            end
            default:
            begin
                thr_next = '0;
            end
        endcase
    end

    // Weights sum to 256 and channels stay below 256, so the sum fits.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_data_next.chan[i] = 8'((prod_bot_reg[i] + prod_top_reg[i]) >> 8);
        end
        s2_data_next.thr  = thr_reg;
        s2_data_next.last = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixels.valid && s1_ready)
        begin
            prod_bot_reg <= prod_bot_next;
            prod_top_reg <= prod_top_next;
            thr_reg      <= thr_next;
            last_reg     <= pixels.last_pixel;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign blend_valid = s2_valid_reg;
    assign blend_data  = s2_data_reg;

endmodule

// ----- hw/rtl/btd_dither.sv -----
module btd_dither (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            blend_valid,
    output logic            blend_ready,
    input  btd_pkg::blend_t blend_data,
    btd_res_if.source       results
);

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [btd_pkg::PIXEL_W-1:0]        pixel_reg;
    logic [btd_pkg::PIXEL_W-1:0]        pixel_next;
    logic                               eol_reg;
    logic [2:0][btd_pkg::CHAN_W-1:0]    sat_ch;
    logic [btd_pkg::CHAN_W:0]           sum;

    assign blend_ready    = !out_valid_reg || results.ready;
    assign out_valid_next = blend_ready ? blend_valid : out_valid_reg;

    // Threshold add saturates at full scale, then packing drops the low bits.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum = {1'b0, blend_data.chan[i]}
                + {{(btd_pkg::CHAN_W+1-btd_pkg::THR_W){1'b0}}, blend_data.thr[i]};
            sat_ch[i] = sum[btd_pkg::CHAN_W] ? {btd_pkg::CHAN_W{1'b1}}
                                             : sum[btd_pkg::CHAN_W-1:0];
        end
        pixel_next = {sat_ch[0][7:3], sat_ch[1][7:2], sat_ch[2][7:3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blend_valid && blend_ready)
        begin
            pixel_reg <= pixel_next;
            eol_reg   <= blend_data.last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.pixel_out   = pixel_reg;
    assign results.end_of_line = eol_reg;

endmodule

// ----- hw/rtl/blend_then_dither_rgb565.sv -----
// Path: an accepted word is registered in the products, blend and dither-and-pack stages in turn,
// and is offered as a result from the dither-and-pack stage register.
// Throughput: one word per clock; each stage advances when the one after it has room.
// Reset clears the stage valid bits and loads alpha 255 and the color dither mode.
module blend_then_dither_rgb565 (
    input  logic                            clk,
    input  logic                            rst_n,
    btd_pix_if.sink                         pixels,
    btd_res_if.source                       results,
    input  logic                            wr_en,
    input  logic [btd_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [btd_pkg::CFG_DATA_W-1:0]  wr_data
);

    btd_pkg::cfg_t   cfg;
    logic            blend_valid;
    logic            blend_ready;
    btd_pkg::blend_t blend_data;

    btd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    btd_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixels      (pixels),
        .blend_valid (blend_valid),
        .blend_ready (blend_ready),
        .blend_data  (blend_data)
    );

    btd_dither u_dither (
        .clk         (clk),
        .rst_n       (rst_n),
        .blend_valid (blend_valid),
        .blend_ready (blend_ready),
        .blend_data  (blend_data),
        .results     (results)
    );

endmodule

// ----- hw/rtl/btd_checker.sv -----
`include "assert_macros.svh"

module btd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [btd_pkg::PIXEL_W-1:0] pixel_out,
    input logic                        end_of_line
);

    // A stalled result word stays offered and unchanged.
    `BTD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `BTD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(pixel_out) && $stable(end_of_line))

    // The input side only backs up once every stage is full and the output is stalled.
    `BTD_ASSERT_SAME(a_in_backpressure, clk, rst_n, !in_ready, out_valid && !out_ready)

    // With the output side open, an accepted word reaches the output once it has passed every stage.
    `BTD_ASSERT_NEXT(a_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready ##1 out_ready, out_valid)

endmodule

bind blend_then_dither_rgb565 btd_checker u_btd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pixels.valid),
    .in_ready    (pixels.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .pixel_out   (results.pixel_out),
    .end_of_line (results.end_of_line)
);
